// ===== rtl/cll_pkg.sv =====
package cll_pkg;

   localparam int unsigned POS_W    = 24;
   localparam int unsigned LINE_W   = 16;
   localparam int unsigned COL_W    = 16;
   localparam int unsigned KIND_W   = 7;
   localparam int unsigned ERR_W    = 4;
   localparam int unsigned KW_BYTES = 8;
   localparam int unsigned KW_W     = 8 * KW_BYTES;
   localparam int unsigned KLEN_W   = $clog2(KW_BYTES + 2);
   localparam int unsigned Q_DEPTH  = 8;

   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;
   localparam logic [COL_W-1:0]  COL_MAX  = '1;

   // token kinds
   localparam logic [KIND_W-1:0] K_SINGLE_BASE = 7'd27;
   localparam logic [KIND_W-1:0] K_DOT         = 7'd35;
   localparam logic [KIND_W-1:0] K_SHL_EQ      = 7'd65;
   localparam logic [KIND_W-1:0] K_SHL         = 7'd66;
   localparam logic [KIND_W-1:0] K_SHR_EQ      = 7'd69;
   localparam logic [KIND_W-1:0] K_SHR         = 7'd70;
   localparam logic [KIND_W-1:0] K_IDENT       = 7'd72;
   localparam logic [KIND_W-1:0] K_NUMBER      = 7'd73;
   localparam logic [KIND_W-1:0] K_CHAR        = 7'd74;
   localparam logic [KIND_W-1:0] K_STRING      = 7'd75;
   localparam logic [KIND_W-1:0] K_ERROR       = 7'd76;
   localparam logic [KIND_W-1:0] K_EOF         = 7'd77;

   // error codes
   localparam logic [ERR_W-1:0] E_NONE         = 4'd0;
   localparam logic [ERR_W-1:0] E_UNEXPECTED   = 4'd0;
   localparam logic [ERR_W-1:0] E_NO_HEX       = 4'd1;
   localparam logic [ERR_W-1:0] E_NO_BIN       = 4'd2;
   localparam logic [ERR_W-1:0] E_FLOAT        = 4'd3;
   localparam logic [ERR_W-1:0] E_OPEN_CHAR    = 4'd4;
   localparam logic [ERR_W-1:0] E_EMPTY_CHAR   = 4'd5;
   localparam logic [ERR_W-1:0] E_NO_QUOTE     = 4'd6;
   localparam logic [ERR_W-1:0] E_OPEN_STRING  = 4'd7;
   localparam logic [ERR_W-1:0] E_OPEN_COMMENT = 4'd8;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam logic [KW_W-1:0] KW_TEXT [27] = '{
      "and", "as", "break", "case", "continue", "default", "do", "else", "extern",
      "false", "for", "fun", "goto", "if", "nil", "or", "packed", "return",
      "sizeof", "switch", "section", "struct", "static", "true", "union", "var",
      "while"};

   localparam logic [7:0] SINGLE_CHARS [12] = '{
      "(", ")", "{", "}", "[", "]", ";", ",", ".", ":", "?", "~"};

   localparam logic [7:0] PAIR_A [17] = '{
      "+", "+", "-", "-", "-", "*", "/", "%", "^", "&", "&", "|", "|", "!", "=", "<", ">"};
   localparam logic [7:0] PAIR_B [17] = '{
      "+", "=", ">", "-", "=", "=", "=", "=", "=", "&", "=", "|", "=", "=", "=", "=", "="};
   localparam logic [KIND_W-1:0] PAIR_KIND [17] = '{
      7'd39, 7'd40, 7'd42, 7'd43, 7'd44, 7'd46, 7'd48, 7'd50, 7'd52, 7'd54, 7'd55,
      7'd57, 7'd58, 7'd60, 7'd62, 7'd64, 7'd68};

   localparam logic [7:0] LONE_CHARS [12] = '{
      "+", "-", "*", "/", "%", "^", "&", "|", "!", "=", "<", ">"};
   localparam logic [KIND_W-1:0] LONE_KIND [12] = '{
      7'd41, 7'd45, 7'd47, 7'd49, 7'd51, 7'd53, 7'd56, 7'd59, 7'd61, 7'd63, 7'd67,
      7'd71};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ERR_W-1:0]  err;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  len;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  col;
      logic              last;
   } tok_type;

   typedef struct packed {
      logic [1:0]        count;
      tok_type [2:0]     slot;
   } push_type;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
   endfunction

   function automatic logic is_bin(input logic [7:0] b);
      return b == "0" || b == "1";
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
      logic [KIND_W-1:0] k;
      k = K_ERROR;
      for (int i = 0; i < 12; i++)
         if (SINGLE_CHARS[i] == b) k = K_SINGLE_BASE + KIND_W'(i);
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] lone_kind(input logic [7:0] b);
      logic [KIND_W-1:0] k;
      k = K_ERROR;
      for (int i = 0; i < 12; i++)
         if (LONE_CHARS[i] == b) k = LONE_KIND[i];
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      logic [KIND_W-1:0] k;
      k = K_ERROR;
      for (int i = 0; i < 17; i++)
         if (PAIR_A[i] == a && PAIR_B[i] == b) k = PAIR_KIND[i];
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_W-1:0] pre,
                                                  input logic [KLEN_W-1:0] len);
      logic [KIND_W-1:0] k;
      k = K_IDENT;
      if (len <= KLEN_W'(KW_BYTES))
         for (int i = 0; i < 27; i++)
            if (pre == KW_TEXT[i]) k = KIND_W'(i);
      return k;
   endfunction

endpackage

// ===== rtl/cll_if.sv =====
interface cll_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_source;

   modport source (output valid, char_byte, end_of_source, input ready);
   modport sink   (input valid, char_byte, end_of_source, output ready);
endinterface

interface cll_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  token_kind;
   logic [3:0]  error_code;
   logic [23:0] start_offset;
   logic [23:0] token_length;
   logic [15:0] line_number;
   logic [15:0] column_number;
   logic        last_of_run;

   modport source (output valid, token_kind, error_code, start_offset, token_length,
                   line_number, column_number, last_of_run, input ready);
   modport sink   (input valid, token_kind, error_code, start_offset, token_length,
                   line_number, column_number, last_of_run, output ready);
endinterface

// ===== rtl/cll_scan.sv =====
module cll_scan import cll_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_byte,
   input  logic       end_of_source,
   output push_type   push
);

   typedef enum logic [4:0] {
      M_IDLE, M_OP, M_OP3, M_LINEC, M_BLOCK, M_BSTAR, M_IDENT, M_ZERO, M_DEC,
      M_DOT, M_HEX0, M_HEX, M_BIN0, M_BIN, M_SUF, M_COPEN, M_CESC, M_CBODY,
      M_STR, M_SESC
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  tb_ff, tb_in, pos_ff, pos_in;
   logic [COL_W-1:0]  tc_ff, tc_in, cc_ff, cc_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [POS_W:0]    lb_ff, lb_in;
   logic [KW_W-1:0]   pre_ff, pre_in;
   logic [KLEN_W-1:0] ilen_ff, ilen_in;
   logic [1:0]        suf_ff, suf_in;
   logic [7:0]        pend_ff, pend_in;

   logic [POS_W-1:0]  p, d;
   logic [POS_W:0]    pe, p1, de, d1;
   logic [COL_W-1:0]  col_p, col_d;

   function automatic logic [COL_W-1:0] col_of(input logic [POS_W-1:0] q,
                                                input logic [POS_W:0] lb);
      logic [POS_W:0] dd;
      dd = {1'b0, q} - lb + 1'b1;
      if ({1'b0, q} < lb) return COL_W'(1);
      if (dd > {{(POS_W+1-COL_W){1'b0}}, COL_MAX}) return COL_MAX;
      return dd[COL_W-1:0];
   endfunction

   function automatic tok_type mk(input logic [KIND_W-1:0] kind, input logic [ERR_W-1:0] err,
                                  input logic [POS_W-1:0] start, input logic [POS_W:0] fin,
                                  input logic [COL_W-1:0] col, input logic [LINE_W-1:0] line);
      tok_type t;
      logic [POS_W:0] len;
      len = (fin > {1'b0, start}) ? fin - {1'b0, start} : '0;
      t.kind  = kind;
      t.err   = err;
      t.start = start;
      t.len   = len[POS_W] ? POS_MAX : len[POS_W-1:0];
      t.line  = line;
      t.col   = col;
      t.last  = 1'b0;
      return t;
   endfunction

   assign p     = pos_ff;
   assign d     = (pos_ff != '0) ? pos_ff - 1'b1 : '0;
   assign pe    = {1'b0, p};
   assign p1    = {1'b0, p} + 1'b1;
   assign de    = {1'b0, d};
   assign d1    = {1'b0, d} + 1'b1;
   assign col_p = col_of(p, lb_ff);
   assign col_d = col_of(d, lb_ff);

   // decode one byte (current mode, then number suffix, then idle scan), or flush at end of source
   always_comb begin
      logic          go_idle, go_suf, do_nl;
      logic [1:0]    n, sflags;
      tok_type [2:0] slot;
      logic [KIND_W-1:0] pk;
      logic [7:0]    b;

      b = char_byte;
      mode_in = mode_ff; tb_in = tb_ff; tc_in = tc_ff; cc_in = cc_ff; pos_in = pos_ff;
      line_in = line_ff; lb_in = lb_ff; pre_in = pre_ff; ilen_in = ilen_ff;
      suf_in = suf_ff; pend_in = pend_ff;
      go_idle = 1'b0; go_suf = 1'b0; do_nl = 1'b0; n = '0; sflags = '0;
      slot = '0; pk = K_ERROR;

      if (accept && end_of_source) begin
         // flush the pending token, then EOF, then restart
         case (mode_ff)
            M_OP: begin
               slot[n] = mk(lone_kind(pend_ff), E_NONE, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            M_OP3: begin
               slot[n] = mk((pend_ff == "<") ? K_SHL : K_SHR, E_NONE, tb_ff, pe, tc_ff, line_ff);
               n = n + 2'd1;
            end
            M_BLOCK, M_BSTAR: begin
               slot[n] = mk(K_ERROR, E_OPEN_COMMENT, tb_ff, pe, cc_ff, line_ff); n = n + 2'd1;
            end
            M_IDENT: begin
               slot[n] = mk(kw_kind(pre_ff, ilen_ff), E_NONE, tb_ff, pe, tc_ff, line_ff);
               n = n + 2'd1;
            end
            M_ZERO, M_DEC, M_HEX, M_BIN, M_SUF: begin
               slot[n] = mk(K_NUMBER, E_NONE, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            M_DOT: begin
               slot[n] = mk(K_NUMBER, E_NONE, tb_ff, de, tc_ff, line_ff); n = n + 2'd1;
               slot[n] = mk(K_DOT, E_NONE, d, d1, col_d, line_ff); n = n + 2'd1;
            end
            M_HEX0: begin
               slot[n] = mk(K_ERROR, E_NO_HEX, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            M_BIN0: begin
               slot[n] = mk(K_ERROR, E_NO_BIN, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            M_COPEN, M_CESC: begin
               slot[n] = mk(K_ERROR, E_OPEN_CHAR, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            M_CBODY: begin
               slot[n] = mk(K_ERROR, E_NO_QUOTE, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            M_STR, M_SESC: begin
               slot[n] = mk(K_ERROR, E_OPEN_STRING, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
            end
            default: ;
         endcase
         slot[n] = mk(K_EOF, E_NONE, p, pe, col_p, line_ff); n = n + 2'd1;
         mode_in = M_IDLE; tb_in = '0; tc_in = COL_W'(1); cc_in = COL_W'(1); pos_in = '0;
         line_in = LINE_W'(1); lb_in = '0; pre_in = '0; ilen_in = '0; suf_in = '0;
         pend_in = '0;
      end else if (accept) begin
         // current mode
         case (mode_ff)
            M_IDLE: go_idle = 1'b1;
            M_OP: begin
               if (pend_ff == "/" && b == "/") mode_in = M_LINEC;
               else if (pend_ff == "/" && b == "*") mode_in = M_BLOCK;
               else if ((pend_ff == "<" || pend_ff == ">") && b == pend_ff) mode_in = M_OP3;
               else begin
                  mode_in = M_IDLE;
                  pk = pair_kind(pend_ff, b);
                  if (pk != K_ERROR) begin
                     slot[n] = mk(pk, E_NONE, tb_ff, p1, tc_ff, line_ff); n = n + 2'd1;
                  end else begin
                     slot[n] = mk(lone_kind(pend_ff), E_NONE, tb_ff, pe, tc_ff, line_ff);
                     n = n + 2'd1;
                     go_idle = 1'b1;
                  end
               end
            end
            M_OP3: begin
               mode_in = M_IDLE;
               if (b == "=") begin
                  slot[n] = mk((pend_ff == "<") ? K_SHL_EQ : K_SHR_EQ, E_NONE, tb_ff, p1, tc_ff,
                               line_ff);
                  n = n + 2'd1;
               end else begin
                  slot[n] = mk((pend_ff == "<") ? K_SHL : K_SHR, E_NONE, tb_ff, pe, tc_ff,
                               line_ff);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_LINEC: if (b == CH_LF) go_idle = 1'b1;
            M_BLOCK, M_BSTAR: begin
               if (mode_ff == M_BSTAR && b == "/") mode_in = M_IDLE;
               else begin
                  do_nl = (b == CH_LF);
                  mode_in = (b == "*") ? M_BSTAR : M_BLOCK;
               end
            end
            M_IDENT: begin
               if (is_alpha(b) || is_digit(b)) begin
                  if (ilen_ff < KLEN_W'(KW_BYTES)) pre_in = {pre_ff[KW_W-9:0], b};
                  if (ilen_ff <= KLEN_W'(KW_BYTES)) ilen_in = ilen_ff + 1'b1;
               end else begin
                  slot[n] = mk(kw_kind(pre_ff, ilen_ff), E_NONE, tb_ff, pe, tc_ff, line_ff);
                  n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_ZERO, M_DEC: begin
               if (mode_ff == M_ZERO && (b == "x" || b == "X")) mode_in = M_HEX0;
               else if (mode_ff == M_ZERO && (b == "b" || b == "B")) mode_in = M_BIN0;
               else if (is_digit(b)) mode_in = M_DEC;
               else if (b == ".") mode_in = M_DOT;
               else go_suf = 1'b1;
            end
            M_DOT: begin
               if (is_digit(b)) begin
                  slot[n] = mk(K_ERROR, E_FLOAT, tb_ff, de, tc_ff, line_ff); n = n + 2'd1;
                  slot[n] = mk(K_DOT, E_NONE, d, d1, col_d, line_ff); n = n + 2'd1;
                  tb_in = p; tc_in = col_p;
                  mode_in = (b == "0") ? M_ZERO : M_DEC;
               end else begin
                  slot[n] = mk(K_NUMBER, E_NONE, tb_ff, de, tc_ff, line_ff); n = n + 2'd1;
                  slot[n] = mk(K_DOT, E_NONE, d, d1, col_d, line_ff); n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_HEX0: begin
               if (is_hex(b)) mode_in = M_HEX;
               else begin
                  slot[n] = mk(K_ERROR, E_NO_HEX, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_BIN0: begin
               if (is_bin(b)) mode_in = M_BIN;
               else begin
                  slot[n] = mk(K_ERROR, E_NO_BIN, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_HEX: if (!is_hex(b)) go_suf = 1'b1;
            M_BIN: if (!is_bin(b)) go_suf = 1'b1;
            M_SUF: begin
               sflags = suf_ff;
               go_suf = 1'b1;
            end
            M_COPEN, M_CESC: begin
               if (mode_ff == M_COPEN && b == "\\") mode_in = M_CESC;
               else if (mode_ff == M_COPEN && b == "'") begin
                  slot[n] = mk(K_ERROR, E_EMPTY_CHAR, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
                  go_idle = 1'b1;
               end else begin
                  do_nl = (b == CH_LF);
                  mode_in = M_CBODY;
               end
            end
            M_CBODY: begin
               mode_in = M_IDLE;
               if (b == "'") begin
                  slot[n] = mk(K_CHAR, E_NONE, tb_ff, p1, tc_ff, line_ff); n = n + 2'd1;
               end else begin
                  slot[n] = mk(K_ERROR, E_NO_QUOTE, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
                  go_idle = 1'b1;
               end
            end
            M_STR: begin
               if (b == "\"") begin
                  slot[n] = mk(K_STRING, E_NONE, tb_ff, p1, tc_ff, line_ff); n = n + 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  do_nl = (b == CH_LF);
                  if (b == "\\") mode_in = M_SESC;
               end
            end
            M_SESC: begin
               do_nl = (b == CH_LF);
               mode_in = M_STR;
            end
            default: go_idle = 1'b1;
         endcase

         // number suffix
         if (go_suf) begin
            if ((b == "u" || b == "U") && !sflags[0]) begin
               suf_in = sflags | 2'b01; mode_in = M_SUF;
            end else if ((b == "l" || b == "L") && !sflags[1]) begin
               suf_in = sflags | 2'b10; mode_in = M_SUF;
            end else begin
               suf_in = sflags;
               slot[n] = mk(K_NUMBER, E_NONE, tb_ff, pe, tc_ff, line_ff); n = n + 2'd1;
               go_idle = 1'b1;
            end
         end

         // scan between tokens
         if (go_idle) begin
            mode_in = M_IDLE;
            if (b == CH_LF) do_nl = 1'b1;
            else if (b != " " && b != CH_CR && b != CH_TAB) begin
               tb_in = p; tc_in = col_p;
               if (is_alpha(b)) begin
                  pre_in = {{(KW_W-8){1'b0}}, b}; ilen_in = KLEN_W'(1); mode_in = M_IDENT;
               end else if (is_digit(b)) mode_in = (b == "0") ? M_ZERO : M_DEC;
               else if (single_kind(b) != K_ERROR) begin
                  slot[n] = mk(single_kind(b), E_NONE, p, p1, col_p, line_ff); n = n + 2'd1;
               end else if (b == "'") mode_in = M_COPEN;
               else if (b == "\"") mode_in = M_STR;
               else if (lone_kind(b) != K_ERROR) begin
                  pend_in = b; mode_in = M_OP;
                  if (b == "/") cc_in = col_p;
               end else begin
                  slot[n] = mk(K_ERROR, E_UNEXPECTED, p, p1, col_p, line_ff); n = n + 2'd1;
               end
            end
         end

         if (do_nl) begin
            line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
            lb_in = p1;
         end
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
      end

      if (n != '0) slot[n - 2'd1].last = 1'b1;
      push.count = n;
      push.slot  = slot;
   end

   // hold scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         tb_ff   <= '0;
         tc_ff   <= COL_W'(1);
         cc_ff   <= COL_W'(1);
         pos_ff  <= '0;
         line_ff <= LINE_W'(1);
         lb_ff   <= '0;
         pre_ff  <= '0;
         ilen_ff <= '0;
         suf_ff  <= '0;
         pend_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         tb_ff   <= tb_in;
         tc_ff   <= tc_in;
         cc_ff   <= cc_in;
         pos_ff  <= pos_in;
         line_ff <= line_in;
         lb_ff   <= lb_in;
         pre_ff  <= pre_in;
         ilen_ff <= ilen_in;
         suf_ff  <= suf_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// ===== rtl/cll_emit.sv =====
module cll_emit import cll_pkg::*; #(
   parameter int unsigned DEPTH = Q_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      space_ok,
   cll_rsp_if.source rsp
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tok_type            q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               vld_ff;
   tok_type            out_ff;
   logic               pop;

   assign space_ok = cnt_ff <= CNT_W'(DEPTH - 3);
   assign pop      = (cnt_ff != '0) && (!vld_ff || rsp.ready);

   // write up to three tokens per request
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++)
         if (2'(k) < push.count) q_ff[wr_ff + PTR_W'(k)] <= push.slot[k];
   end

   // advance pointers and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         wr_ff  <= wr_ff + PTR_W'(push.count);
         rd_ff  <= rd_ff + PTR_W'(pop);
         cnt_ff <= cnt_ff + CNT_W'(push.count) - CNT_W'(pop);
         if (pop) vld_ff <= 1'b1;
         else if (rsp.ready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) out_ff <= q_ff[rd_ff];
   end

   assign rsp.valid         = vld_ff;
   assign rsp.token_kind    = out_ff.kind;
   assign rsp.error_code    = out_ff.err;
   assign rsp.start_offset  = out_ff.start;
   assign rsp.token_length  = out_ff.len;
   assign rsp.line_number   = out_ff.line;
   assign rsp.column_number = out_ff.col;
   assign rsp.last_of_run   = out_ff.last;

endmodule

// ===== rtl/c_like_source_lexer_top.sv =====
// channel | dir | payload                                    | accept
// req     | in  | char_byte, end_of_source                   | valid && ready
// rsp     | out | kind, error, offset, length, line, column, | valid && ready
//         |     | last_of_run                                |
//
// One request per cycle while req.ready is high; the scanner decodes a byte
// and pushes up to three tokens into a token queue of QUEUE_DEPTH entries.
// Tokens leave through an output register, one per cycle unless stalled.
// req.ready drops only while the queue holds fewer than three free entries.
// Synchronous reset clears scanner state and empties the queue.
module c_like_source_lexer_top import cll_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   cll_req_if.sink   req,
   cll_rsp_if.source rsp
);

   push_type push;
   logic     space_ok;

   assign req.ready = space_ok;

   cll_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (req.valid && space_ok),
      .char_byte     (req.char_byte),
      .end_of_source (req.end_of_source),
      .push          (push)
   );

   cll_emit #(.DEPTH(QUEUE_DEPTH)) u_emit (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp)
   );

endmodule

// ===== rtl/cll_checker.sv =====
module cll_checker import cll_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_kind,
   input logic [ERR_W-1:0]  rsp_err,
   input logic [LINE_W-1:0] rsp_line,
   input logic [COL_W-1:0]  rsp_col,
   input logic              rsp_last
);

   // hold a stalled token
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("token dropped while stalled");

   // EOF closes its request
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == K_EOF |-> rsp_last)
      else $error("EOF not last of run");

   // error code only on error tokens
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != K_ERROR |-> rsp_err == E_NONE)
      else $error("error code on non-error token");

   // line and column count from one
   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line != '0 && rsp_col != '0)
      else $error("zero line or column");

endmodule

bind c_like_source_lexer_top cll_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_kind  (rsp.token_kind),
   .rsp_err   (rsp.error_code),
   .rsp_line  (rsp.line_number),
   .rsp_col   (rsp.column_number),
   .rsp_last  (rsp.last_of_run)
);
